[src/bra_pkg.sv]
// ----------------------------------------------------------------------------
// bra_pkg: shared types and constants for the barometric altitude block
// Status codes, request and response structs of the altitude engine and the
// shared divider, and the function that builds log2 table entries.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int DEF_MAX_BASELINE_SAMPLES = 256;
  localparam int DEF_LOG_TABLE_ENTRIES    = 64;

  localparam logic [20:0] STD_PRESSURE_Q4  = 21'd1621200;
  localparam int          INV_EXPONENT_Q16 = 12471;
  localparam int          SCALE_HEIGHT_M   = 44330;
  localparam logic [16:0] ONE_Q16          = 17'd65536;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_MEASURED     = 3'd0,
    ST_FAILED       = 3'd1,
    ST_BASE_TAKEN   = 3'd2,
    ST_BASE_SET     = 3'd3,
    ST_BASE_DEFAULT = 3'd4
  } status_t;

  // Request to the altitude engine.
  typedef struct packed {
    logic        start;
    logic        use_mean;
    logic [20:0] pressure;
    logic [31:0] sum;
  } alt_req_t;

  // Response of the altitude engine.
  typedef struct packed {
    logic               done;
    logic signed [31:0] alt_q8;
    logic [20:0]        mean_q4;
  } alt_rsp_t;

  // Request to the shared divider.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  // Response of the shared divider.
  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  // Fractional log2 in Q16 of a Q30 value in [1,2), by repeated squaring.
  function automatic logic [16:0] log_frac(input logic [63:0] x_in);
    logic [63:0] x;
    logic [16:0] r;
    x = x_in;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      x = (x * x) >> 30;
      if (x >= 64'h8000_0000) begin
        x = x >> 1;
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

[src/bra_div.sv]
// ----------------------------------------------------------------------------
// bra_div: shared restoring divider
// Divides a 32-bit dividend by a 17-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bra_div (
  input  logic               clk,
  input  logic               rst,
  input  bra_pkg::div_req_t  req,
  output bra_pkg::div_rsp_t  rsp
);

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [31:0] dvd;
  logic [16:0] dvs;
  logic [16:0] rem;

  logic [17:0] rem_sh;
  logic        take;
  logic [17:0] rem_next;

  // One restoring step.
  always_comb begin
    rem_sh   = {rem, dvd[31]};
    take     = rem_sh >= {1'b0, dvs};
    rem_next = take ? (rem_sh - {1'b0, dvs}) : rem_sh;
  end

  // Iteration control; the dividend register fills with quotient bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        dvd <= {dvd[30:0], take};
        rem <= rem_next[16:0];
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy <= 1'b1;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
        cnt  <= '0;
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

[src/bra_alt.sv]
// ----------------------------------------------------------------------------
// bra_alt: standard-atmosphere altitude engine
// Sequencer that computes altitude in meters (Q8) from a Q4 pressure through
// a table-based log2, a scaled exponent and a table-based exp2. Divisions by
// a variable go through the shared divider, which also forms the baseline
// mean. The table size is a power of two, so division by it is a shift.
// ----------------------------------------------------------------------------
module bra_alt #(
  parameter int LOG_TABLE_ENTRIES = bra_pkg::DEF_LOG_TABLE_ENTRIES,
  parameter int COUNT_W           = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  bra_pkg::alt_req_t  req,
  input  logic [COUNT_W-1:0] count,
  output bra_pkg::alt_rsp_t  rsp
);

  localparam int N   = LOG_TABLE_ENTRIES;
  localparam int IW  = $clog2(N);
  localparam int TW  = $clog2(N + 1);
  localparam int NW  = $clog2(N + 1);
  localparam int TNW = 20 + NW;
  localparam int BW  = $clog2(IW);

  // log2 of the standard pressure, worked out at elaboration.
  localparam longint LS_FRAC = longint'(bra_pkg::STD_PRESSURE_Q4) - (64'd1 << 20);
  localparam longint LS_TN   = LS_FRAC * N;
  localparam longint LS_IDX  = LS_TN >> 20;
  localparam longint LS_REM  = LS_TN % (64'd1 << 20);
  localparam logic [63:0] LS_X0 = 64'h4000_0000 + ((64'(LS_IDX) << 30) / LOG_TABLE_ENTRIES);
  localparam logic [63:0] LS_X1 =
    64'h4000_0000 + ((64'(LS_IDX + 1) << 30) / LOG_TABLE_ENTRIES);
  localparam longint LS_LO = longint'(bra_pkg::log_frac(LS_X0));
  localparam longint LS_HI = (LS_IDX + 1 == N) ? 65536 : longint'(bra_pkg::log_frac(LS_X1));
  localparam longint LS_LOG = (longint'(20) << 16) + LS_LO + (((LS_HI - LS_LO) * LS_REM) >> 20);
  localparam logic signed [22:0] LSTD = 23'(LS_LOG);

  // Constant log2(1 + i/N) table in Q16.
  logic [16:0] log_tab [N+1];
  for (genvar g = 0; g <= N; g++) begin : g_tab
    localparam logic [63:0] X = 64'h4000_0000 + ((64'(g) << 30) / LOG_TABLE_ENTRIES);
    assign log_tab[g] = (g == N) ? bra_pkg::ONE_Q16 : bra_pkg::log_frac(X);
  end

  typedef enum logic [3:0] {
    A_IDLE, A_MEAN, A_NORM, A_LOGM, A_LOGI, A_LOGS, A_SRCH,
    A_QDIV, A_QWAIT, A_MDIV, A_SHIFT, A_ALT, A_FIN
  } alt_state_t;

  alt_state_t          state;
  bra_pkg::div_req_t   div_req;
  bra_pkg::div_rsp_t   div_rsp;

  logic [20:0]         p;
  logic [4:0]          sh;
  logic [TNW-1:0]      tn;
  logic [21:0]         lg_base;
  logic [36:0]         iprod;
  logic signed [38:0]  yprod;
  logic [IW-1:0]       ii;
  logic [BW-1:0]       bitp;
  logic [31:0]         q;
  logic [17:0]         m;
  logic [25:0]         pw;
  logic signed [43:0]  altprod;
  logic signed [31:0]  alt;
  logic [20:0]         mean;
  logic                done;

  logic [IW-1:0]       idx;
  logic [16:0]         lo_l, hi_l, hi_eff;
  logic [4:0]          e;
  logic [21:0]         lval;
  logic signed [22:0]  d;
  logic signed [5:0]   ip;
  logic [15:0]         f;
  logic [IW-1:0]       srch_c;
  logic                srch_ok;
  logic [16:0]         q_lo, q_hi;
  logic [3:0]          shamt;
  logic [6:0]          neg;
  logic [25:0]         pw_next;
  logic signed [26:0]  one_minus;

  bra_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Table reads, log assembly, exponent search and power shift.
  always_comb begin
    idx     = IW'(tn >> 20);
    lo_l    = log_tab[TW'(idx)];
    hi_l    = log_tab[TW'(idx) + TW'(1)];
    hi_eff  = (hi_l < lo_l) ? lo_l : hi_l;
    e       = 5'd20 - sh;
    lval    = lg_base + 22'(iprod >> 20);
    d       = $signed({1'b0, lval}) - LSTD;
    ip      = yprod[37:32];
    f       = yprod[31:16];
    srch_c  = ii | (IW'(1) << bitp);
    srch_ok = (srch_c <= IW'(N - 1)) && (log_tab[TW'(srch_c)] <= {1'b0, f});
    q_lo    = log_tab[TW'(ii)];
    q_hi    = log_tab[TW'(ii) + TW'(1)];
    shamt   = (ip > 6'sd8) ? 4'd8 : ip[3:0];
    neg     = 7'(-$signed({ip[5], ip}));
    if (!ip[5]) begin
      pw_next = 26'(m) << shamt;
    end else if (neg > 7'd40) begin
      pw_next = '0;
    end else begin
      pw_next = 26'(m >> neg);
    end
    one_minus = 27'sd65536 - $signed({1'b0, pw});
  end

  // Sequencer with its datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= A_IDLE;
      done          <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      done          <= 1'b0;
      div_req.start <= 1'b0;
      unique case (state)
        A_IDLE: begin
          sh <= '0;
          if (req.start) begin
            if (req.use_mean) begin
              div_req.start    <= 1'b1;
              div_req.dividend <= req.sum;
              div_req.divisor  <= 17'(count);
              state            <= A_MEAN;
            end else begin
              p     <= (req.pressure == '0) ? 21'd1 : req.pressure;
              state <= A_NORM;
            end
          end
        end
        A_MEAN: begin
          if (div_rsp.done) begin
            mean  <= div_rsp.quotient[20:0];
            p     <= (div_rsp.quotient[20:0] == '0) ? 21'd1 : div_rsp.quotient[20:0];
            state <= A_NORM;
          end
        end
        A_NORM: begin
          if (p[20]) begin
            state <= A_LOGM;
          end else begin
            p  <= {p[19:0], 1'b0};
            sh <= sh + 5'd1;
          end
        end
        A_LOGM: begin
          tn    <= TNW'(p[19:0]) * TNW'(N);
          state <= A_LOGI;
        end
        A_LOGI: begin
          iprod   <= 37'(hi_eff - lo_l) * 37'(tn[19:0]);
          lg_base <= {1'b0, e, 16'h0000} + 22'(lo_l);
          state   <= A_LOGS;
        end
        A_LOGS: begin
          yprod <= 39'(d) * 39'sd12471;
          ii    <= '0;
          bitp  <= BW'(IW - 1);
          state <= A_SRCH;
        end
        A_SRCH: begin
          if (srch_ok) begin
            ii <= srch_c;
          end
          if (bitp == '0) begin
            state <= A_QDIV;
          end else begin
            bitp <= bitp - BW'(1);
          end
        end
        A_QDIV: begin
          if (q_hi > q_lo) begin
            div_req.start    <= 1'b1;
            div_req.dividend <= ({1'b0, f} > q_lo) ?
                                {16'(17'({1'b0, f}) - q_lo), 16'h0000} : 32'd0;
            div_req.divisor  <= q_hi - q_lo;
            state            <= A_QWAIT;
          end else begin
            q     <= '0;
            state <= A_MDIV;
          end
        end
        A_QWAIT: begin
          if (div_rsp.done) begin
            q     <= div_rsp.quotient;
            state <= A_MDIV;
          end
        end
        // Mantissa: one plus the interpolated index over the table size.
        A_MDIV: begin
          m     <= 18'(32'd65536 + ((32'({ii, 16'h0000}) + q) >> IW));
          state <= A_SHIFT;
        end
        A_SHIFT: begin
          pw    <= pw_next;
          state <= A_ALT;
        end
        A_ALT: begin
          altprod <= 44'(one_minus) * 44'sd44330;
          state   <= A_FIN;
        end
        A_FIN: begin
          alt   <= altprod[39:8];
          done  <= 1'b1;
          state <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

  assign rsp.done    = done;
  assign rsp.alt_q8  = alt;
  assign rsp.mean_q4 = mean;

endmodule

[src/baro_relative_altitude.sv]
// ----------------------------------------------------------------------------
// baro_relative_altitude: barometric altitude above a ground baseline
// Collects baseline samples, sets the baseline pressure and its altitude,
// and reports pressure, temperature and relative altitude per measurement.
//
//   channel  | signals                                        | direction
//   ---------+------------------------------------------------+----------
//   input    | in_valid in_ready func reading_ok pressure_q4  | in
//            | temp_q8 last_sample                            |
//   output   | out_valid out_ready status pressure_pa         | out
//            | temp_centi rel_alt_cm baseline_q4              |
//
// A baseline sample that does not close the baseline, a failed measurement
// and a default baseline go from acceptance straight to the output hold
// state. A measurement runs the altitude engine, with extra normalization
// shifts for pressures below 65536 Pa and one pass through the shared
// divider. Closing a baseline with valid samples adds one more divider
// pass for the mean. Reset is synchronous; the block takes one transaction
// at a time and holds a finished result in the output register while the
// next is taken.
// ----------------------------------------------------------------------------
module baro_relative_altitude #(
  parameter int MAX_BASELINE_SAMPLES = bra_pkg::DEF_MAX_BASELINE_SAMPLES,
  parameter int LOG_TABLE_ENTRIES    = bra_pkg::DEF_LOG_TABLE_ENTRIES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic               reading_ok,
  input  logic [20:0]        pressure_q4,
  input  logic signed [15:0] temp_q8,
  input  logic               last_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic signed [17:0] pressure_pa,
  output logic signed [14:0] temp_centi,
  output logic signed [15:0] rel_alt_cm,
  output logic [20:0]        baseline_q4
);

  localparam int CW = $clog2(MAX_BASELINE_SAMPLES + 1);

  typedef enum logic [1:0] {T_IDLE, T_START, T_WAIT, T_HOLD} top_state_t;

  top_state_t          state;
  logic [31:0]         sum;
  logic [CW-1:0]       count;
  logic [20:0]         baseline;
  logic signed [31:0]  base_alt;
  logic                mode_base;
  logic [20:0]         item_p;
  bra_pkg::status_t    res_status;
  logic signed [17:0]  res_pa;
  logic signed [14:0]  res_tc;
  logic signed [15:0]  res_cm;
  bra_pkg::status_t    out_status;

  bra_pkg::alt_req_t   alt_req;
  bra_pkg::alt_rsp_t   alt_rsp;

  logic                in_fire;
  logic                count_inc;
  logic [CW-1:0]       count_new;
  logic signed [22:0]  tc_prod, tc_adj;
  logic signed [32:0]  diff;
  logic signed [40:0]  cm_prod, cm_adj;
  logic signed [32:0]  cm_q;
  logic signed [15:0]  cm_sat;
  logic                out_free;

  bra_alt #(
    .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES),
    .COUNT_W           (CW)
  ) u_alt (
    .clk   (clk),
    .rst   (rst),
    .req   (alt_req),
    .count (count),
    .rsp   (alt_rsp)
  );

  // Request to the altitude engine.
  always_comb begin
    alt_req.start    = (state == T_START);
    alt_req.use_mean = mode_base;
    alt_req.pressure = item_p;
    alt_req.sum      = sum;
  end

  // Handshake, sample count and the scaled temperature and altitude.
  always_comb begin
    in_ready  = (state == T_IDLE);
    in_fire   = in_valid && in_ready;
    out_free  = !out_valid || out_ready;
    count_inc = reading_ok && (count < CW'(MAX_BASELINE_SAMPLES));
    count_new = count + CW'(count_inc);
    tc_prod   = 23'(temp_q8) * 23'sd100;
    tc_adj    = tc_prod + (tc_prod[22] ? 23'sd255 : 23'sd0);
    diff      = 33'(alt_rsp.alt_q8) - 33'(base_alt);
    cm_prod   = 41'(diff) * 41'sd100;
    cm_adj    = cm_prod + (cm_prod[40] ? 41'sd255 : 41'sd0);
    cm_q      = cm_adj[40:8];
    if (cm_q > 33'sd32767) begin
      cm_sat = 16'sh7fff;
    end else if (cm_q < -33'sd32768) begin
      cm_sat = 16'sh8000;
    end else begin
      cm_sat = cm_q[15:0];
    end
  end

  // Control sequencer, baseline state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      out_valid <= 1'b0;
      sum       <= '0;
      count     <= '0;
      baseline  <= bra_pkg::STD_PRESSURE_Q4;
      base_alt  <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (in_fire) begin
            item_p <= pressure_q4;
            if (!func) begin
              mode_base  <= 1'b1;
              res_status <= bra_pkg::ST_BASE_TAKEN;
              res_pa     <= '0;
              res_tc     <= '0;
              res_cm     <= '0;
              if (count_inc) begin
                sum <= sum + 32'(pressure_q4);
              end
              count <= count_new;
              if (last_sample) begin
                if (count_new != '0) begin
                  state <= T_START;
                end else begin
                  baseline   <= bra_pkg::STD_PRESSURE_Q4;
                  base_alt   <= '0;
                  sum        <= '0;
                  count      <= '0;
                  res_status <= bra_pkg::ST_BASE_DEFAULT;
                  state      <= T_HOLD;
                end
              end else begin
                state <= T_HOLD;
              end
            end else if (!reading_ok) begin
              res_status <= bra_pkg::ST_FAILED;
              res_pa     <= '1;
              res_tc     <= '1;
              res_cm     <= '1;
              state      <= T_HOLD;
            end else begin
              mode_base  <= 1'b0;
              res_status <= bra_pkg::ST_MEASURED;
              res_pa     <= 18'(pressure_q4 >> 4);
              res_tc     <= tc_adj[22:8];
              state      <= T_START;
            end
          end
        end
        T_START: begin
          state <= T_WAIT;
        end
        T_WAIT: begin
          if (alt_rsp.done) begin
            if (mode_base) begin
              baseline   <= alt_rsp.mean_q4;
              base_alt   <= alt_rsp.alt_q8;
              sum        <= '0;
              count      <= '0;
              res_status <= bra_pkg::ST_BASE_SET;
            end else begin
              res_cm <= cm_sat;
            end
            state <= T_HOLD;
          end
        end
        T_HOLD: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_status  <= res_status;
            pressure_pa <= res_pa;
            temp_centi  <= res_tc;
            rel_alt_cm  <= res_cm;
            baseline_q4 <= baseline;
            state       <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  assign status = 3'(out_status);

`ifndef SYNTH
  // The sample count never passes its limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_BASELINE_SAMPLES))
    else $error("baseline sample count above limit");

  // The altitude engine only finishes while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    alt_rsp.done |-> (state == T_WAIT))
    else $error("altitude result outside wait state");

  // An accepted transaction closes the input until its result is queued.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input taken while busy");

  // A default baseline result reports the standard pressure.
  a_default_base: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == 3'(bra_pkg::ST_BASE_DEFAULT)))
      |-> (baseline_q4 == bra_pkg::STD_PRESSURE_Q4))
    else $error("default baseline not standard pressure");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for baro_relative_altitude
// Sends baseline collections and flight measurements over the input channel
// with random gaps and output stalls. It predicts every result with its own
// fixed-point altitude model and compares each field in order of arrival.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic FUNC_BASELINE = 1'b0;
  localparam logic FUNC_MEASURE  = 1'b1;
  localparam int   NUM_ITEMS     = 1950;
  localparam int   CYCLE_LIMIT   = 2000000;
  localparam int   LOG_N         = 64;
  localparam int   SAMPLE_CAP    = 256;

  typedef struct {
    logic               func;
    logic               ok;
    logic [20:0]        pressure;
    logic signed [15:0] temp;
    logic               last;
    logic               drain;
  } reading_t;

  typedef struct {
    bra_pkg::status_t   status;
    logic signed [17:0] pa;
    logic signed [14:0] tc;
    logic signed [15:0] cm;
    logic [20:0]        base;
  } altitude_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = 1'b0;
  logic reading_ok = 1'b0;
  logic [20:0] pressure_q4 = '0;
  logic signed [15:0] temp_q8 = '0;
  logic last_sample = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic signed [17:0] pressure_pa;
  logic signed [14:0] temp_centi;
  logic signed [15:0] rel_alt_cm;
  logic [20:0] baseline_q4;

  reading_t         pending_readings[$];
  altitude_result_t expected_results[$];
  longint unsigned  log2_tab[LOG_N + 1];
  bit [31:0]        sum_acc;
  int unsigned      sample_count;
  logic [20:0]      base_pressure;
  int               base_alt_q8;
  int               cycle_count = 0;
  int               error_count = 0;
  bit               drain_wait = 1'b0;

  baro_relative_altitude u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .reading_ok(reading_ok), .pressure_q4(pressure_q4),
    .temp_q8(temp_q8), .last_sample(last_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .pressure_pa(pressure_pa), .temp_centi(temp_centi),
    .rel_alt_cm(rel_alt_cm), .baseline_q4(baseline_q4)
  );

  always #4 clk = ~clk;

  // Fractional log2 table in Q16, built by bit-by-bit squaring.
  function automatic void build_log_table();
    longint unsigned x;
    longint unsigned r;
    for (int i = 0; i < LOG_N; i++) begin
      x = (64'd1 << 30) + ((longint'(i) << 30) / LOG_N);
      r = 0;
      for (int b = 15; b >= 0; b--) begin
        x = (x * x) >> 30;
        if (x >= (64'd1 << 31)) begin
          x = x >> 1;
          r = r | (64'd1 << b);
        end
      end
      log2_tab[i] = r;
    end
    log2_tab[LOG_N] = 65536;
  endfunction

  // log2 of a Q4 pressure word, Q16, by table interpolation.
  function automatic longint log2_pressure(logic [20:0] p_in);
    longint unsigned p, t, tn, rem, lo, hi;
    int e;
    int idx;
    p = (p_in == 0) ? 1 : p_in;
    e = 0;
    while (e < 31 && (p >> (e + 1)) != 0) e++;
    t = ((p << 30) >> e) - (64'd1 << 30);
    tn = t * LOG_N;
    idx = int'(tn >> 30);
    if (idx >= LOG_N) idx = LOG_N - 1;
    rem = tn - (longint'(idx) << 30);
    lo = log2_tab[idx];
    hi = log2_tab[idx + 1];
    if (hi < lo) hi = lo;
    return (longint'(e) << 16) + longint'(lo + (((hi - lo) * rem) >> 30));
  endfunction

  // 2^y with y and the result in Q16, using the inverted log table.
  function automatic longint pow2_q16(longint y);
    longint ip;
    longint unsigned f, lo, hi, q, m;
    int i;
    ip = y >>> 16;
    f = y - ip * 65536;
    i = 0;
    for (int k = 1; k < LOG_N; k++)
      if (log2_tab[k] <= f) i = k;
    lo = log2_tab[i];
    hi = log2_tab[i + 1];
    q = (f > lo) ? (f - lo) << 16 : 0;
    q = (hi > lo) ? q / (hi - lo) : 0;
    m = 65536 + (((longint'(i) << 16) + q) / LOG_N);
    if (ip >= 0) return longint'(m << (ip > 8 ? 8 : ip));
    if (ip < -40) return 0;
    return longint'(m >> (-ip));
  endfunction

  // Standard-atmosphere altitude of a pressure, meters in signed Q8.
  function automatic int std_altitude_q8(logic [20:0] p);
    longint d, y, pw, a;
    d = log2_pressure(p) - log2_pressure(bra_pkg::STD_PRESSURE_Q4);
    y = (d * bra_pkg::INV_EXPONENT_Q16) >>> 16;
    pw = pow2_q16(y);
    a = (longint'(bra_pkg::SCALE_HEIGHT_M) * (65536 - pw)) >>> 8;
    return int'(a);
  endfunction

  // Advances the baseline state by one transaction and returns its result.
  function automatic altitude_result_t predict_altitude(reading_t r);
    altitude_result_t res;
    longint cm;
    res.pa = '0;
    res.tc = '0;
    res.cm = '0;
    if (r.func == FUNC_BASELINE) begin
      res.status = bra_pkg::ST_BASE_TAKEN;
      if (r.ok && sample_count < SAMPLE_CAP) begin
        sum_acc += r.pressure;
        sample_count++;
      end
      if (r.last) begin
        if (sample_count > 0) begin
          base_pressure = 21'(sum_acc / sample_count);
          res.status = bra_pkg::ST_BASE_SET;
        end else begin
          base_pressure = bra_pkg::STD_PRESSURE_Q4;
          res.status = bra_pkg::ST_BASE_DEFAULT;
        end
        base_alt_q8 = std_altitude_q8(base_pressure);
        sum_acc = 0;
        sample_count = 0;
      end
    end else if (!r.ok) begin
      res.status = bra_pkg::ST_FAILED;
      res.pa = -1;
      res.tc = -1;
      res.cm = -1;
    end else begin
      res.status = bra_pkg::ST_MEASURED;
      res.pa = 18'(r.pressure >> 4);
      res.tc = 15'((longint'(r.temp) * 100) / 256);
      cm = ((longint'(std_altitude_q8(r.pressure)) - base_alt_q8) * 100) / 256;
      if (cm > 32767) cm = 32767;
      if (cm < -32768) cm = -32768;
      res.cm = 16'(cm);
    end
    res.base = base_pressure;
    return res;
  endfunction

  function automatic bit idle_now();
    if (cycle_count > 20000 && cycle_count < 60000) return 1'b0;
    return $urandom_range(0, 99) < 30;
  endfunction

  // Input driver: presents queued readings and predicts each accepted one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        reading_t acc;
        acc.func = func;
        acc.ok = reading_ok;
        acc.pressure = pressure_q4;
        acc.temp = temp_q8;
        acc.last = last_sample;
        acc.drain = 1'b0;
        expected_results.push_back(predict_altitude(acc));
      end
      if (!in_valid || in_ready) begin
        if (pending_readings.size() > 0 && pending_readings[0].drain && !drain_wait)
          drain_wait = 1'b1;
        if (drain_wait && expected_results.size() == 0 && !(in_valid && in_ready))
          drain_wait = 1'b0;
        if (pending_readings.size() > 0 && !drain_wait && !idle_now()) begin
          reading_t nxt;
          nxt = pending_readings.pop_front();
          func <= nxt.func;
          reading_ok <= nxt.ok;
          pressure_q4 <= nxt.pressure;
          temp_q8 <= nxt.temp;
          last_sample <= nxt.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: random backpressure and field-by-field comparison.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, status %0d", $time, status);
          error_count++;
        end else begin
          altitude_result_t ex;
          ex = expected_results.pop_front();
          if (status !== ex.status) begin
            $display("%0t: status expected %0d actual %0d", $time, ex.status, status);
            error_count++;
          end
          if (pressure_pa !== ex.pa) begin
            $display("%0t: pressure_pa expected %0d actual %0d", $time, ex.pa, pressure_pa);
            error_count++;
          end
          if (temp_centi !== ex.tc) begin
            $display("%0t: temp_centi expected %0d actual %0d", $time, ex.tc, temp_centi);
            error_count++;
          end
          if (rel_alt_cm !== ex.cm) begin
            $display("%0t: rel_alt_cm expected %0d actual %0d", $time, ex.cm, rel_alt_cm);
            error_count++;
          end
          if (baseline_q4 !== ex.base) begin
            $display("%0t: baseline_q4 expected %0d actual %0d", $time, ex.base, baseline_q4);
            error_count++;
          end
        end
      end
      out_ready <= !idle_now();
    end
  end

  // Cycle counter with a timeout guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic add_reading(logic f, logic ok, logic [20:0] p, logic signed [15:0] t,
                             logic last, logic drain = 1'b0);
    reading_t r;
    r.func = f;
    r.ok = ok;
    r.pressure = p;
    r.temp = t;
    r.last = last;
    r.drain = drain;
    pending_readings.push_back(r);
  endtask

  function automatic logic [20:0] random_pressure();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return 21'($urandom_range(60000 * 16, 110000 * 16));
    if (sel < 90) return 21'($urandom_range(0, 2000000));
    return 21'(int'(base_pressure) + $urandom_range(0, 400) - 200);
  endfunction

  function automatic logic signed [15:0] random_temp();
    return 16'(int'($urandom_range(0, 32000)) - 10240);
  endfunction

  // Stimulus: directed corners, then random baseline and flight sequences.
  initial begin
    int n;
    int len;
    build_log_table();
    sum_acc = 0;
    sample_count = 0;
    base_pressure = bra_pkg::STD_PRESSURE_Q4;
    base_alt_q8 = 0;

    // Measurements against the reset baseline, including range extremes.
    add_reading(FUNC_MEASURE, 1'b1, bra_pkg::STD_PRESSURE_Q4, 16'sd0, 1'b0);
    add_reading(FUNC_MEASURE, 1'b1, 21'd0, -16'sd10240, 1'b0);
    add_reading(FUNC_MEASURE, 1'b1, 21'd2000000, 16'sd21760, 1'b1);
    add_reading(FUNC_MEASURE, 1'b1, 21'd1, 16'sd255, 1'b0);
    add_reading(FUNC_MEASURE, 1'b1, 21'd1621216, -16'sd1, 1'b0);
    add_reading(FUNC_MEASURE, 1'b0, 21'd1600000, 16'sd5000, 1'b0);
    add_reading(FUNC_MEASURE, 1'b1, 21'd1621199, 16'sd100, 1'b0);
    // Closing with no valid sample falls back to the default baseline.
    add_reading(FUNC_BASELINE, 1'b0, 21'd1500000, 16'sd0, 1'b0);
    add_reading(FUNC_BASELINE, 1'b0, 21'd1400000, 16'sd0, 1'b1);
    // Baseline with valid and failed samples, then measurements near it.
    add_reading(FUNC_BASELINE, 1'b1, 21'd1600000, 16'sd0, 1'b0);
    add_reading(FUNC_BASELINE, 1'b0, 21'd100, 16'sd0, 1'b0);
    add_reading(FUNC_BASELINE, 1'b1, 21'd1600003, 16'sd0, 1'b0);
    add_reading(FUNC_BASELINE, 1'b1, 21'd1600005, 16'sd0, 1'b1);
    add_reading(FUNC_MEASURE, 1'b1, 21'd1600002, 16'sd2560, 1'b0);
    add_reading(FUNC_MEASURE, 1'b1, 21'd1600010, 16'sd2560, 1'b0);
    add_reading(FUNC_MEASURE, 1'b1, 21'd1599990, -16'sd2560, 1'b0);
    add_reading(FUNC_MEASURE, 1'b1, 21'd900000, 16'sd1000, 1'b0);
    // Baseline at the largest and smallest pressures.
    add_reading(FUNC_BASELINE, 1'b1, 21'd2000000, 16'sd0, 1'b1);
    add_reading(FUNC_MEASURE, 1'b1, 21'd0, 16'sd0, 1'b0);
    add_reading(FUNC_BASELINE, 1'b1, 21'd0, 16'sd0, 1'b1, 1'b1);
    add_reading(FUNC_MEASURE, 1'b1, 21'd2000000, 16'sd0, 1'b0);
    n = 21;

    // More valid samples than the baseline collects; the surplus is dropped.
    for (int i = 0; i < 270; i++)
      add_reading(FUNC_BASELINE, 1'b1, 21'(i < 256 ? 1500000 + i : 10), 16'sd0, i == 269);
    n += 270;

    while (n < NUM_ITEMS) begin
      if ($urandom_range(0, 99) < 15) begin
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++)
          add_reading(FUNC_BASELINE, $urandom_range(0, 99) < 85,
                      21'($urandom_range(60000 * 16, 110000 * 16)), random_temp(),
                      i == len - 1, i == 0 && $urandom_range(0, 19) == 0);
        n += len;
      end else begin
        add_reading(FUNC_MEASURE, $urandom_range(0, 99) < 90, random_pressure(),
                    random_temp(), 1'($urandom_range(0, 1)));
        n++;
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    wait (pending_readings.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (300) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
